### design/ldnw_pkg.sv
// ----------------------------------------------------------------------------
// LCD decimal number writer package
// Shared types, constants and the power-of-ten table.
// ----------------------------------------------------------------------------
package ldnw_pkg;

    localparam logic [7:0] CMD_HOME   = 8'h80;
    localparam logic [7:0] LINE1_BASE = 8'h80;
    localparam logic [7:0] LINE2_BASE = 8'hC0;
    localparam logic [7:0] LINE3_BASE = 8'h94;
    localparam logic [7:0] LINE4_BASE = 8'hD4;
    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [7:0] ASCII_E    = 8'h45;

    localparam logic RS_COMMAND = 1'b0;
    localparam logic RS_DATA    = 1'b1;

    // Highest decimal position that is ever printed.
    localparam logic [2:0] TOP_POS = 3'd5;

    // Request to the nibble transmitter: one byte, sent as two beats.
    typedef struct packed {
        logic       load;
        logic       rs;
        logic [7:0] data;
        logic       last;
    } t_tx_req;

    // Control of the shared compare-subtract unit.
    typedef struct packed {
        logic load;
        logic step;
        logic clr;
    } t_du_ctrl;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CMD  = 5'b00010,
        S_DIV  = 5'b00100,
        S_CHAR = 5'b01000,
        S_E    = 5'b10000
    } t_state;

    // Weight of decimal position pos (1 is the units digit).
    function automatic logic [13:0] pow10(input logic [2:0] pos);
        logic [13:0] w;
        begin
            unique case (pos)
                3'd1:    w = 14'd1;
                3'd2:    w = 14'd10;
                3'd3:    w = 14'd100;
                3'd4:    w = 14'd1000;
                3'd5:    w = 14'd10000;
                default: w = 14'd1;
            endcase
            return w;
        end
    endfunction

endpackage

### design/lcd_decimal_number_writer_unit.sv
// ----------------------------------------------------------------------------
// LCD decimal number writer
// Turns a print request into HD44780 4-bit bus nibble writes.
// ----------------------------------------------------------------------------
// Each request beat carries a row, a column, a value and a digit count, and
// produces a cursor command byte followed by ASCII digits, every byte sent
// as a high-nibble beat and then a low-nibble beat; tuser is the register
// select and tlast marks the final beat of the request. The block takes one
// request at a time and drops s_axis_tready until all its bytes are handed
// to the output register. The digits come from one compare-subtract unit
// that subtracts 10000, 1000, 100, 10 and 1 in turn, one subtraction per
// cycle while no digit waits for the output register. A request passes
// through acceptance, then the command byte when there is one, then the
// 'E' byte when the count is above five, or otherwise, for each of the five
// positions, the subtractions for its digit value and, when that digit is
// printed, its byte. Each byte occupies the output register for its two
// beats and an empty reload slot after them, so a byte waits when the
// previous one has not yet drained.
module lcd_decimal_number_writer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [2:0] row, [8:3] column,
                                        // [24:9] value, [28:25] digits
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [3:0] nibble
    output logic        m_axis_tuser,   // [0] reg_select
    output logic        m_axis_tlast
);
    import ldnw_pkg::*;

    t_state      r_state;
    t_state      n_state;
    logic [3:0]  r_digits;
    logic [3:0]  n_digits;
    logic [7:0]  r_cmd;
    logic [7:0]  n_cmd;
    logic [2:0]  r_pos;
    logic [2:0]  n_pos;

    logic [2:0]  w_row;
    logic [5:0]  w_col;
    logic [15:0] w_value;
    logic [3:0]  w_digits;
    logic        w_accept;
    logic        w_has_cmd;
    logic [7:0]  w_base;
    logic [7:0]  w_cmd;

    t_du_ctrl    w_du;
    t_tx_req     w_tx;
    logic        w_du_ge;
    logic [3:0]  w_du_count;
    logic        w_tx_idle;

    assign w_row    = s_axis_tdata[2:0];
    assign w_col    = s_axis_tdata[8:3];
    assign w_value  = s_axis_tdata[24:9];
    assign w_digits = s_axis_tdata[28:25];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        unique case (w_row)
            3'd1:    w_base = LINE1_BASE;
            3'd2:    w_base = LINE2_BASE;
            3'd3:    w_base = LINE3_BASE;
            3'd4:    w_base = LINE4_BASE;
            default: w_base = LINE1_BASE;
        endcase
    end

    // Rows past the fourth line send no command unless the column is zero.
    assign w_has_cmd = (w_row == 3'd0) || (w_col == 6'd0) || (w_row <= 3'd4);
    assign w_cmd = ((w_row == 3'd0) || (w_col == 6'd0))
                 ? CMD_HOME : (w_base + {2'b00, w_col} - 8'd1);

    always_comb begin
        n_state  = r_state;
        n_digits = r_digits;
        n_cmd    = r_cmd;
        n_pos    = r_pos;
        w_du     = '0;
        w_tx     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_digits  = w_digits;
                    n_cmd     = w_cmd;
                    n_pos     = TOP_POS;
                    w_du.load = 1'b1;
                    if (w_has_cmd) begin
                        n_state = S_CMD;
                    end else if (w_digits > 4'd5) begin
                        n_state = S_E;
                    end else if (w_digits != 4'd0) begin
                        n_state = S_DIV;
                    end
                end
            end
            S_CMD: begin
                if (w_tx_idle) begin
                    w_tx.load = 1'b1;
                    w_tx.rs   = RS_COMMAND;
                    w_tx.data = r_cmd;
                    w_tx.last = (r_digits == 4'd0);
                    if (r_digits > 4'd5) begin
                        n_state = S_E;
                    end else if (r_digits != 4'd0) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DIV: begin
                if (w_du_ge) begin
                    w_du.step = 1'b1;
                end else if ({1'b0, r_pos} <= r_digits) begin
                    n_state = S_CHAR;
                end else begin
                    // Position above the requested count: drop its digit.
                    w_du.clr = 1'b1;
                    n_pos    = r_pos - 3'd1;
                end
            end
            S_CHAR: begin
                if (w_tx_idle) begin
                    w_tx.load = 1'b1;
                    w_tx.rs   = RS_DATA;
                    w_tx.data = ASCII_ZERO + {4'b0000, w_du_count};
                    w_tx.last = (r_pos == 3'd1);
                    w_du.clr  = 1'b1;
                    n_pos     = r_pos - 3'd1;
                    n_state   = (r_pos == 3'd1) ? S_IDLE : S_DIV;
                end
            end
            S_E: begin
                if (w_tx_idle) begin
                    w_tx.load = 1'b1;
                    w_tx.rs   = RS_DATA;
                    w_tx.data = ASCII_E;
                    w_tx.last = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digits <= n_digits;
        r_cmd    <= n_cmd;
        r_pos    <= n_pos;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    ldnw_digit_unit u_digit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_du),
        .i_value (w_value),
        .i_pos   (r_pos),
        .o_ge    (w_du_ge),
        .o_count (w_du_count)
    );

    ldnw_nibble_tx u_tx (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (w_tx),
        .o_idle        (w_tx_idle),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### design/ldnw_digit_unit.sv
// ----------------------------------------------------------------------------
// LCD decimal number writer: digit unit
// Shared compare-subtract unit that peels decimal digits off the value by
// repeated subtraction of a power of ten, one subtraction per cycle.
// ----------------------------------------------------------------------------
module ldnw_digit_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ldnw_pkg::t_du_ctrl  i_ctrl,
    input  logic [15:0]         i_value,
    input  logic [2:0]          i_pos,
    output logic                o_ge,
    output logic [3:0]          o_count
);
    import ldnw_pkg::*;

    logic [15:0] r_rem;
    logic [15:0] n_rem;
    logic [3:0]  r_cnt;
    logic [3:0]  n_cnt;
    logic [15:0] w_weight;

    assign w_weight = {2'b00, pow10(i_pos)};
    assign o_ge     = (r_rem >= w_weight);
    assign o_count  = r_cnt;

    always_comb begin
        n_rem = r_rem;
        n_cnt = r_cnt;
        if (i_ctrl.load) begin
            n_rem = i_value;
            n_cnt = 4'd0;
        end else if (i_ctrl.step) begin
            n_rem = r_rem - w_weight;
            n_cnt = r_cnt + 4'd1;
        end else if (i_ctrl.clr) begin
            n_cnt = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        if (!i_rst_n) begin
            r_cnt <= 4'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

### design/ldnw_nibble_tx.sv
// ----------------------------------------------------------------------------
// LCD decimal number writer: nibble transmitter
// Output register that sends one byte as a high-nibble beat and then a
// low-nibble beat.
// ----------------------------------------------------------------------------
module ldnw_nibble_tx (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ldnw_pkg::t_tx_req  i_req,
    output logic               o_idle,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // [3:0] nibble, [7:4] zero
    output logic               m_axis_tuser,   // [0] reg_select
    output logic               m_axis_tlast
);
    import ldnw_pkg::*;

    logic       r_valid;
    logic       r_hi;
    logic       r_rs;
    logic       r_last;
    logic [7:0] r_byte;
    logic       w_beat;

    assign w_beat        = r_valid && m_axis_tready;
    assign o_idle        = !r_valid;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {4'b0000, (r_hi ? r_byte[7:4] : r_byte[3:0])};
    assign m_axis_tuser  = r_rs;
    assign m_axis_tlast  = r_last && !r_hi;

    always_ff @(posedge i_clk) begin
        if (i_req.load && !r_valid) begin
            r_byte <= i_req.data;
            r_rs   <= i_req.rs;
            r_last <= i_req.last;
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hi    <= 1'b1;
        end else if (i_req.load && !r_valid) begin
            r_valid <= 1'b1;
            r_hi    <= 1'b1;
        end else if (w_beat) begin
            if (r_hi) begin
                r_hi <= 1'b0;
            end else begin
                r_valid <= 1'b0;
                r_hi    <= 1'b1;
            end
        end
    end

endmodule

### tb/sv/lcd_write_checker.sv
// ----------------------------------------------------------------------------
// LCD write stream checker
// Watches the request and nibble streams of the LCD decimal number writer,
// predicts the HD44780 nibble writes of every accepted request and compares
// each output beat with the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lcd_write_checker
    import ldnw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [31:0] i_req_data,    // [2:0] row, [8:3] column,
                                       // [24:9] value, [28:25] digits
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_data,    // [3:0] nibble
    input  logic        i_out_user,    // [0] reg_select
    input  logic        i_out_last,
    input  logic        i_done,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic       rs;
        logic [3:0] nibble;
        logic       last;
    } nibble_write_t;

    nibble_write_t lcd_write_q[$];
    nibble_write_t want;
    logic          leftovers_checked = 1'b0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    task automatic report_mismatch(input string what, input int want_val, input int got_val);
        begin
            $display("%0t ns: %s: expected %0h, got %0h", $time, what, want_val, got_val);
            o_errors++;
        end
    endtask

    // Cursor command byte (if any), then the requested digits as ASCII, each
    // byte split into a high and a low nibble; the final nibble carries last.
    task automatic queue_lcd_writes(input logic [2:0] row, input logic [5:0] column,
                                    input logic [15:0] value, input logic [3:0] digits);
        logic [7:0]    bytes [6];
        logic          rs_of [6];
        int            count;
        int            weight;
        int            digit;
        logic [7:0]    base;
        nibble_write_t beat;
        begin
            count = 0;
            if (row == 3'd0 || column == 6'd0) begin
                bytes[count] = CMD_HOME;
                rs_of[count] = RS_COMMAND;
                count++;
            end else if (row <= 3'd4) begin
                case (row)
                    3'd1:    base = LINE1_BASE;
                    3'd2:    base = LINE2_BASE;
                    3'd3:    base = LINE3_BASE;
                    default: base = LINE4_BASE;
                endcase
                bytes[count] = base + {2'b00, column} - 8'd1;
                rs_of[count] = RS_COMMAND;
                count++;
            end

            if (digits >= 4'd1 && digits <= 4'd5) begin
                for (int k = digits; k >= 1; k--) begin
                    weight = 1;
                    for (int j = 1; j < k; j++)
                        weight = weight * 10;
                    digit = int'(value) / weight;
                    // The top position is not reduced mod 10.
                    if (k != 5)
                        digit = digit % 10;
                    bytes[count] = ASCII_ZERO + 8'(digit);
                    rs_of[count] = RS_DATA;
                    count++;
                end
            end else if (digits > 4'd5) begin
                bytes[count] = ASCII_E;
                rs_of[count] = RS_DATA;
                count++;
            end

            for (int b = 0; b < count; b++) begin
                beat.rs     = rs_of[b];
                beat.nibble = bytes[b][7:4];
                beat.last   = 1'b0;
                lcd_write_q.push_back(beat);
                beat.nibble = bytes[b][3:0];
                beat.last   = (b == count - 1);
                lcd_write_q.push_back(beat);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_req_valid && i_req_ready)
                queue_lcd_writes(i_req_data[2:0], i_req_data[8:3], i_req_data[24:9],
                                 i_req_data[28:25]);

            if (i_out_valid && i_out_ready) begin
                if (lcd_write_q.size() == 0) begin
                    report_mismatch("output beat with nothing expected", 0, i_out_data);
                end else begin
                    want = lcd_write_q.pop_front();
                    if (i_out_user !== want.rs)
                        report_mismatch("reg_select", want.rs, i_out_user);
                    if (i_out_data[3:0] !== want.nibble)
                        report_mismatch("nibble", want.nibble, i_out_data[3:0]);
                    if (i_out_last !== want.last)
                        report_mismatch("last", want.last, i_out_last);
                end
            end

            if (i_done && !leftovers_checked) begin
                leftovers_checked = 1'b1;
                if (lcd_write_q.size() != 0)
                    report_mismatch("beats never delivered", 0, lcd_write_q.size());
            end
        end
        o_pending = lcd_write_q.size();
    end

endmodule

### tb/sv/tb_lcd_decimal_number_writer_unit.sv
// ----------------------------------------------------------------------------
// LCD decimal number writer testbench
// Drives print requests with random gaps and output stalls, and lets the
// stream checker judge every nibble write the block produces.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_lcd_decimal_number_writer_unit;

    localparam int RANDOM_REQUESTS = 92;
    localparam int QUIET_TAIL      = 20;
    localparam int DRAIN_CYCLES    = 80;
    localparam int CYCLE_LIMIT     = 200000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;     // [2:0] row, [8:3] column,
                                         // [24:9] value, [28:25] digits
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // [3:0] nibble
    logic        m_axis_tuser;           // [0] reg_select
    logic        m_axis_tlast;

    logic        stream_done   = 1'b0;
    logic        quiet         = 1'b0;
    int          error_cnt;
    int          pending_cnt;
    int          cycle_cnt     = 0;
    int          stall_left    = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    lcd_decimal_number_writer_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    lcd_write_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_data  (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_user  (m_axis_tuser),
        .i_out_last  (m_axis_tlast),
        .i_done      (stream_done),
        .o_errors    (error_cnt),
        .o_pending   (pending_cnt)
    );

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Sink side: stalls come in random bursts, none in the tail.
    always @(posedge i_clk) begin
        if (quiet) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Called just after a rising edge; returns at the edge of the handshake.
    task automatic send_request(input logic [2:0] row, input logic [5:0] column,
                                input logic [15:0] value, input logic [3:0] digits);
        int gap;
        begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 10);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {3'b000, digits, value, column, row};
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_drain();
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while (pending_cnt != 0) @(posedge i_clk);
        end
    endtask

    initial begin
        logic [2:0]  row;
        logic [5:0]  column;
        logic [15:0] value;
        logic [3:0]  digits;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Home by row and by column, every line base, column wrap, the
        // silent rows, the undivided top digit, the 'E' case and no digits.
        send_request(3'd0, 6'd5,  16'd1234,  4'd3);
        send_request(3'd3, 6'd0,  16'd987,   4'd2);
        send_request(3'd1, 6'd1,  16'd0,     4'd1);
        send_request(3'd2, 6'd1,  16'd42,    4'd2);
        send_request(3'd3, 6'd1,  16'd305,   4'd3);
        send_request(3'd4, 6'd1,  16'd9999,  4'd4);
        send_request(3'd1, 6'd63, 16'd65535, 4'd5);
        send_request(3'd4, 6'd63, 16'd0,     4'd5);
        send_request(3'd2, 6'd63, 16'd12345, 4'd5);
        send_request(3'd5, 6'd7,  16'd777,   4'd0);
        send_request(3'd6, 6'd63, 16'd65535, 4'd0);
        send_request(3'd7, 6'd1,  16'd31,    4'd2);
        send_request(3'd7, 6'd63, 16'd65535, 4'd15);
        send_request(3'd1, 6'd10, 16'd500,   4'd6);
        send_request(3'd0, 6'd0,  16'd65535, 4'd15);
        send_request(3'd2, 6'd20, 16'd1000,  4'd0);
        send_request(3'd4, 6'd40, 16'd59999, 4'd5);
        send_request(3'd3, 6'd33, 16'd40000, 4'd4);

        // Hold off until every predicted nibble has come out.
        wait_for_drain();

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            quiet = (i >= RANDOM_REQUESTS - QUIET_TAIL);
            if (i == RANDOM_REQUESTS / 2)
                wait_for_drain();

            row = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 7) == 0)
                column = 6'd0;
            else
                column = 6'($urandom_range(1, 63));
            if ($urandom_range(0, 3) == 0)
                value = 16'($urandom_range(0, 99));
            else
                value = 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 9) < 8)
                digits = 4'($urandom_range(1, 5));
            else
                digits = 4'($urandom_range(0, 15));
            send_request(row, column, value, digits);
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        stream_done <= 1'b1;
        repeat (2) @(posedge i_clk);

        if (error_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
design/ldnw_pkg.sv
design/ldnw_digit_unit.sv
design/ldnw_nibble_tx.sv
design/lcd_decimal_number_writer_unit.sv
tb/sv/lcd_write_checker.sv
tb/sv/tb_lcd_decimal_number_writer_unit.sv
